// File: rtl/dlte_pkg.sv
// ----------------------------------------------------------------------------
// dlte_pkg
// Types and codes shared by the lease table engine.
// ----------------------------------------------------------------------------
`default_nettype none

package dlte_pkg;

    localparam logic [2:0] CMD_ADD      = 3'd0;
    localparam logic [2:0] CMD_FIND_IP  = 3'd1;
    localparam logic [2:0] CMD_FIND_MAC = 3'd2;
    localparam logic [2:0] CMD_RELEASE  = 3'd3;
    localparam logic [2:0] CMD_RENEW    = 3'd4;
    localparam logic [2:0] CMD_SWEEP    = 3'd5;
    localparam logic [2:0] CMD_CLEANUP  = 3'd6;

    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_NOT_FOUND = 2'd1;
    localparam logic [1:0] STAT_FULL      = 2'd2;

    localparam logic [1:0] BIND_ACTIVE   = 2'd0;
    localparam logic [1:0] BIND_EXPIRED  = 2'd1;
    localparam logic [1:0] BIND_RELEASED = 2'd2;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [31:0] ip_addr;
        logic [47:0] hw_addr;
        logic [31:0] lease_seconds;
        logic [31:0] now_seconds;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [5:0]  slot;
        logic [31:0] ip_addr_out;
        logic [47:0] hw_addr_out;
        logic [31:0] start_out;
        logic [31:0] end_out;
        logic [1:0]  binding_out;
        logic [6:0]  entries;
        logic [6:0]  changed;
    } rsp_t;

    typedef struct packed {
        logic [31:0] ip;
        logic [47:0] mac;
        logic [31:0] start;
        logic [31:0] fin;
        logic [1:0]  binding;
    } lease_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADD,
        ST_READ,
        ST_CHECK,
        ST_EMIT
    } state_t;

endpackage

`default_nettype wire

// File: rtl/dhcp_lease_table_engine.sv
// ----------------------------------------------------------------------------
// dhcp_lease_table_engine
// IPv4 lease table: add, find, release, renew, expire sweep and cleanup.
// ----------------------------------------------------------------------------
// One request at a time. Add writes the new lease, and an unused code goes
// straight to the result; find, release and renew walk the entries up to and
// including the first match, or every entry when nothing matches; sweep and
// cleanup walk every lease. The lease memory has a registered read.
// The result register frees the input side, so a new
// request may enter while a result waits; a request only finishes once the
// previous result has left that register. No clearing pass after reset.
`default_nettype none

module dhcp_lease_table_engine #(
    parameter int TABLE_DEPTH = 64
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output logic               req_stall,
    input  wire dlte_pkg::req_t req,
    output logic               rsp_valid,
    input  wire logic          rsp_stall,
    output dlte_pkg::rsp_t     rsp
);
    import dlte_pkg::*;

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(TABLE_DEPTH);

    lease_t mem [TABLE_DEPTH];
    lease_t rdata_reg;

    state_t            state_reg, state_next;
    req_t              req_reg, req_next;
    rsp_t              res_reg, res_next;
    rsp_t              out_reg, out_next;
    logic              out_valid_reg, out_valid_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic [CNT_W-1:0]  n_reg, n_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [CNT_W-1:0]  total_reg, total_next;

    logic              mem_we;
    logic [IDX_W-1:0]  mem_waddr;
    lease_t            mem_wdata;
    logic [IDX_W-1:0]  mem_raddr;

    logic [32:0] sum;
    logic [31:0] sat_end;
    logic        scan_end;
    logic        hit;
    logic        accept;
    logic        emit_go;
    lease_t      upd;

    assign sum      = {1'b0, req_reg.now_seconds} + {1'b0, req_reg.lease_seconds};
    assign sat_end  = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
    assign scan_end = idx_reg >= total_reg;
    assign hit      = (req_reg.cmd == CMD_FIND_MAC) ? (rdata_reg.mac == req_reg.hw_addr)
                                                   : (rdata_reg.ip == req_reg.ip_addr);
    assign accept   = req_valid && !req_stall;
    assign emit_go  = !out_valid_reg || !rsp_stall;
    assign mem_raddr = idx_reg[IDX_W-1:0];

    assign req_stall = state_reg != ST_IDLE;
    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (req.cmd == CMD_ADD)
                        state_next = ST_ADD;
                    else if (req.cmd == CMD_FIND_IP || req.cmd == CMD_FIND_MAC ||
                             req.cmd == CMD_RELEASE || req.cmd == CMD_RENEW ||
                             req.cmd == CMD_SWEEP || req.cmd == CMD_CLEANUP)
                        state_next = ST_READ;
                    else
                        state_next = ST_EMIT;
                end
            end
            ST_ADD:   state_next = ST_EMIT;
            ST_READ:  state_next = scan_end ? ST_EMIT : ST_CHECK;
            ST_CHECK:
            begin
                if (hit && req_reg.cmd != CMD_SWEEP && req_reg.cmd != CMD_CLEANUP)
                    state_next = ST_EMIT;
                else
                    state_next = ST_READ;
            end
            ST_EMIT:  state_next = emit_go ? ST_IDLE : ST_EMIT;
            default:  state_next = ST_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb
    begin
        req_next       = req_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && rsp_stall;
        idx_next       = idx_reg;
        n_next         = n_reg;
        cnt_next       = cnt_reg;
        total_next     = total_reg;
        mem_we         = 1'b0;
        mem_waddr      = idx_reg[IDX_W-1:0];
        mem_wdata      = rdata_reg;
        upd            = rdata_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    req_next = req;
                    res_next = '0;
                    idx_next = '0;
                    n_next   = '0;
                    cnt_next = '0;
                end
            end
            ST_ADD:
            begin
                if (total_reg >= DEPTH_C)
                    res_next.status = STAT_FULL;
                else
                begin
                    upd.ip      = req_reg.ip_addr;
                    upd.mac     = req_reg.hw_addr;
                    upd.start   = req_reg.now_seconds;
                    upd.fin     = sat_end;
                    upd.binding = BIND_ACTIVE;
                    mem_we      = 1'b1;
                    mem_waddr   = total_reg[IDX_W-1:0];
                    mem_wdata   = upd;
                    res_next.slot        = 6'(total_reg);
                    res_next.ip_addr_out = upd.ip;
                    res_next.hw_addr_out = upd.mac;
                    res_next.start_out   = upd.start;
                    res_next.end_out     = upd.fin;
                    res_next.binding_out = upd.binding;
                    total_next = total_reg + 1'b1;
                end
            end
            ST_READ:
            begin
                if (scan_end)
                begin
                    if (req_reg.cmd == CMD_CLEANUP)
                        total_next = n_reg;
                    else if (req_reg.cmd != CMD_SWEEP)
                        res_next.status = STAT_NOT_FOUND;
                end
            end
            ST_CHECK:
            begin
                if (req_reg.cmd == CMD_SWEEP)
                begin
                    if (rdata_reg.binding == BIND_ACTIVE &&
                        rdata_reg.fin < req_reg.now_seconds)
                    begin
                        upd.binding = BIND_EXPIRED;
                        mem_we      = 1'b1;
                        mem_wdata   = upd;
                        cnt_next    = cnt_reg + 1'b1;
                    end
                    idx_next = idx_reg + 1'b1;
                end
                else if (req_reg.cmd == CMD_CLEANUP)
                begin
                    if (rdata_reg.binding == BIND_EXPIRED ||
                        rdata_reg.binding == BIND_RELEASED)
                        cnt_next = cnt_reg + 1'b1;
                    else
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = n_reg[IDX_W-1:0];
                        n_next    = n_reg + 1'b1;
                    end
                    idx_next = idx_reg + 1'b1;
                end
                else if (hit)
                begin
                    if (req_reg.cmd == CMD_RELEASE)
                    begin
                        upd.binding = BIND_RELEASED;
                        upd.fin     = req_reg.now_seconds;
                        mem_we      = 1'b1;
                    end
                    else if (req_reg.cmd == CMD_RENEW)
                    begin
                        upd.start   = req_reg.now_seconds;
                        upd.fin     = sat_end;
                        upd.binding = BIND_ACTIVE;
                        mem_we      = 1'b1;
                    end
                    mem_wdata            = upd;
                    res_next.slot        = 6'(idx_reg);
                    res_next.ip_addr_out = upd.ip;
                    res_next.hw_addr_out = upd.mac;
                    res_next.start_out   = upd.start;
                    res_next.end_out     = upd.fin;
                    res_next.binding_out = upd.binding;
                end
                else
                    idx_next = idx_reg + 1'b1;
            end
            ST_EMIT:
            begin
                if (emit_go)
                begin
                    out_next         = res_reg;
                    out_next.entries = 7'(total_reg);
                    out_next.changed = 7'(cnt_reg);
                    out_valid_next   = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            total_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            total_reg     <= total_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg <= req_next;
        res_reg <= res_next;
        out_reg <= out_next;
        idx_reg <= idx_next;
        n_reg   <= n_next;
        cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        rdata_reg <= mem[mem_raddr];
    end

    a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
        total_reg <= DEPTH_C)
        else $error("lease count above table depth");

    a_write_state: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == ST_ADD || state_reg == ST_CHECK))
        else $error("table write outside add or check");

    a_compact_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CHECK && req_reg.cmd == CMD_CLEANUP) |-> n_reg <= idx_reg)
        else $error("cleanup write pointer ahead of read pointer");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ || state_reg == ST_CHECK) |-> cnt_reg <= idx_reg)
        else $error("change count exceeds entries walked");

endmodule

`default_nettype wire
